/* hw/rtl/zoned_intrusion_alarm_fsm_unit_defines.svh */
// Assertion macros shared by the checker of the zoned intrusion alarm unit.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ZONED_INTRUSION_ALARM_FSM_UNIT_DEFINES_SVH
`define ZONED_INTRUSION_ALARM_FSM_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define ZIA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ZIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/zia_pkg.sv */
// Package for the zoned intrusion alarm unit: widths, codes, reset values and types.
// No dependencies; imported by the interfaces, the step logic, the top level and the checker.
`default_nettype none

package zia_pkg;

   // zone count and the mask of usable sensor bits (fields are three bits wide)
   localparam int unsigned ZONE_COUNT = 3;
   localparam int unsigned ZONE_W     = 3;
   localparam logic [ZONE_W-1:0] ZONE_MASK = ZONE_W'((1 << ZONE_COUNT) - 1);

   // field widths
   localparam int unsigned CMD_W       = 3;
   localparam int unsigned ZIDX_W      = 2;
   localparam int unsigned MODE_W      = 2;
   localparam int unsigned TZONE_W     = 2;
   localparam int unsigned DELAY_W     = 16;
   localparam int unsigned PERIOD_W    = 10;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_DELAY   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD = CSR_IDX_W'(1);

   localparam logic [DELAY_W-1:0]  ARM_DELAY_RESET   = DELAY_W'(5000);
   localparam logic [PERIOD_W-1:0] TICK_PERIOD_RESET = PERIOD_W'(30);

   // command codes
   localparam logic [CMD_W-1:0] CMD_NONE     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ARM      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DISARM   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_ZONE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_STATUS   = 3'd4;

   // alarm state codes
   localparam logic [MODE_W-1:0] MODE_DISARMED  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ARMING    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ARMED     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TRIGGERED = 2'd3;

   localparam logic [TZONE_W-1:0] TZONE_NONE = 2'd0;

   typedef struct packed {
      logic [DELAY_W-1:0]  arm_delay_ms;
      logic [PERIOD_W-1:0] tick_period_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      arm_delay_ms:   ARM_DELAY_RESET,
      tick_period_ms: TICK_PERIOD_RESET
   };

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [ZONE_W-1:0]  zones;
      logic [ZONE_W-1:0]  prev_sensors;
      logic               primed;
      logic [DELAY_W-1:0] countdown_ms;
      logic [TZONE_W-1:0] fired_zone;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:         MODE_DISARMED,
      zones:        '0,
      prev_sensors: '0,
      primed:       1'b0,
      countdown_ms: '0,
      fired_zone:   TZONE_NONE
   };

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ZIDX_W-1:0] zone_index;
      logic              zone_value;
      logic [ZONE_W-1:0] sensor_bits;
   } item_type;

   typedef struct packed {
      logic [MODE_W-1:0]  alarm_state;
      logic [ZONE_W-1:0]  zone_enables;
      logic [ZONE_W-1:0]  sensors_active;
      logic [TZONE_W-1:0] trigger_zone;
      logic               changed;
      logic               report;
   } result_type;

endpackage

`default_nettype wire

/* hw/rtl/zia_channels.sv */
// Valid/ready channel interfaces for tick beats in and status beats out.
// Depends on zia_pkg for the field widths.
`default_nettype none

interface zia_req_if;
   import zia_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [ZIDX_W-1:0] zone_index;
   logic              zone_value;
   logic [ZONE_W-1:0] sensor_bits;

   modport source (output valid, output cmd, output zone_index, output zone_value,
                   output sensor_bits, input ready);
   modport sink   (input valid, input cmd, input zone_index, input zone_value,
                   input sensor_bits, output ready);
endinterface

interface zia_rsp_if;
   import zia_pkg::*;

   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  alarm_state;
   logic [ZONE_W-1:0]  zone_enables;
   logic [ZONE_W-1:0]  sensors_active;
   logic [TZONE_W-1:0] trigger_zone;
   logic               changed;
   logic               report;

   modport source (output valid, output alarm_state, output zone_enables,
                   output sensors_active, output trigger_zone, output changed,
                   output report, input ready);
   modport sink   (input valid, input alarm_state, input zone_enables,
                   input sensors_active, input trigger_zone, input changed,
                   input report, output ready);
endinterface

`default_nettype wire

/* hw/rtl/zia_step.sv */
// Next-state and status logic for one tick of the zoned intrusion alarm.
// Depends on zia_pkg; purely combinational, instantiated by the top level.
`default_nettype none

module zia_step (
   input  zia_pkg::state_type  state_cur,
   input  zia_pkg::cfg_type    cfg,
   input  zia_pkg::item_type   item,
   output zia_pkg::state_type  state_nxt,
   output zia_pkg::result_type result
);
   import zia_pkg::*;

   always_comb begin
      state_type           s;
      logic [ZONE_W-1:0]   now;
      logic [ZONE_W-1:0]   rising;
      logic [ZONE_W-1:0]   falling;
      logic [ZONE_W-1:0]   bit_sel;
      logic [ZONE_W-1:0]   new_mask;
      logic [ZONE_W-1:0]   hit;
      logic [TZONE_W-1:0]  low_zone;
      logic [DELAY_W-1:0]  period;
      logic                chg;
      logic                command;

      s      = state_cur;
      period = DELAY_W'(cfg.tick_period_ms);

      // edge detect; the priming tick sees no edges
      now     = item.sensor_bits & ZONE_MASK;
      rising  = '0;
      falling = '0;
      if (state_cur.primed) begin
         rising  = now & ~state_cur.prev_sensors & ZONE_MASK;
         falling = ~now & state_cur.prev_sensors & ZONE_MASK;
      end
      s.prev_sensors = now;
      s.primed       = 1'b1;
      chg            = |(rising | falling);

      command = (item.cmd == CMD_ARM) || (item.cmd == CMD_DISARM) ||
                (item.cmd == CMD_SET_ZONE) || (item.cmd == CMD_STATUS);

      // candidate zone mask for a set-enable command
      bit_sel  = ZONE_W'(1) << item.zone_index;
      new_mask = (item.zone_value ? (s.zones | bit_sel) : (s.zones & ~bit_sel)) & ZONE_MASK;

      // command handling
      unique case (item.cmd)
         CMD_ARM: begin
            if (s.mode != MODE_ARMING) begin
               s.mode         = MODE_ARMING;
               s.countdown_ms = cfg.arm_delay_ms;
               s.fired_zone   = TZONE_NONE;
               chg            = 1'b1;
            end
         end
         CMD_DISARM: begin
            if (s.mode != MODE_DISARMED) begin
               s.mode         = MODE_DISARMED;
               s.countdown_ms = '0;
               s.fired_zone   = TZONE_NONE;
               chg            = 1'b1;
            end
         end
         CMD_SET_ZONE: begin
            if ((32'(item.zone_index) < ZONE_COUNT) && (new_mask != s.zones)) begin
               s.zones = new_mask;
               chg     = 1'b1;
            end
         end
         default: ;
      endcase

      // lowest enabled zone with a rising edge, 1-based
      hit = rising & s.zones;
      priority if (hit[0]) low_zone = 2'd1;
      else if (hit[1])     low_zone = 2'd2;
      else if (hit[2])     low_zone = 2'd3;
      else                 low_zone = TZONE_NONE;

      // exit countdown and trigger check
      unique case (s.mode)
         MODE_ARMING: begin
            if (s.countdown_ms <= period) begin
               s.countdown_ms = '0;
               s.mode         = MODE_ARMED;
               chg            = 1'b1;
            end else begin
               s.countdown_ms = s.countdown_ms - period;
            end
         end
         MODE_ARMED: begin
            if (low_zone != TZONE_NONE) begin
               s.mode       = MODE_TRIGGERED;
               s.fired_zone = low_zone;
               chg          = 1'b1;
            end
         end
         default: ;
      endcase

      state_nxt             = s;
      result.alarm_state    = s.mode;
      result.zone_enables   = s.zones;
      result.sensors_active = now;
      result.trigger_zone   = s.fired_zone;
      result.changed        = chg;
      result.report         = command || chg;
   end

endmodule

`default_nettype wire

/* hw/rtl/zoned_intrusion_alarm_fsm_unit.sv */
// Zoned intrusion alarm unit, top level: handshake, registers, config port.
// Latency: a status beat is offered the cycle after its tick beat is taken.
// Throughput: one tick per cycle while the status sink is ready; the single-stage output register sets it.
// Reset (synchronous): disarmed, no zones, unprimed, config to 5000 ms / 30 ms.
// Depends on zia_pkg, zia_channels and zia_step.
`default_nettype none

module zoned_intrusion_alarm_fsm_unit (
   input  logic                            clock,
   input  logic                            reset,
   zia_req_if.sink                         req_ch,
   zia_rsp_if.source                       rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [zia_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [zia_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import zia_pkg::*;

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type result_in;
   item_type   item;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ARM_DELAY:   cfg_ff.arm_delay_ms   <= csr_wr_data[DELAY_W-1:0];
            CSR_TICK_PERIOD: cfg_ff.tick_period_ms <= csr_wr_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: outside reset, take a beat whenever the output register is free or drains
   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   assign item.cmd         = req_ch.cmd;
   assign item.zone_index  = req_ch.zone_index;
   assign item.zone_value  = req_ch.zone_value;
   assign item.sensor_bits = req_ch.sensor_bits;

   zia_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .item      (item),
      .state_nxt (state_in),
      .result    (result_in)
   );

   // alarm state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.alarm_state    = result_ff.alarm_state;
   assign rsp_ch.zone_enables   = result_ff.zone_enables;
   assign rsp_ch.sensors_active = result_ff.sensors_active;
   assign rsp_ch.trigger_zone   = result_ff.trigger_zone;
   assign rsp_ch.changed        = result_ff.changed;
   assign rsp_ch.report         = result_ff.report;

endmodule

`default_nettype wire

/* hw/rtl/zia_checker.sv */
// Port-level assertions for the zoned intrusion alarm unit, bound to the top level.
// Depends on zia_pkg and zoned_intrusion_alarm_fsm_unit_defines.svh.
`default_nettype none
`include "zoned_intrusion_alarm_fsm_unit_defines.svh"

module zia_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [zia_pkg::MODE_W-1:0]    alarm_state,
   input logic [zia_pkg::ZONE_W-1:0]    zone_enables,
   input logic [zia_pkg::ZONE_W-1:0]    sensors_active,
   input logic [zia_pkg::TZONE_W-1:0]   trigger_zone,
   input logic                          changed,
   input logic                          report
);
   import zia_pkg::*;

   // every tick beat taken yields a status beat on the next cycle
   `ZIA_ASSERT_NEXT(a_rsp_follows, clock, reset, req_valid && req_ready, rsp_valid, "status beat missing after tick")

   // a stalled status beat holds
   `ZIA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(alarm_state) && $stable(zone_enables) && $stable(sensors_active) && $stable(trigger_zone) && $stable(changed) && $stable(report), "stalled status beat changed")

   // a trigger zone is reported exactly while triggered
   `ZIA_ASSERT_IMPLY(a_zone_iff_trig, clock, reset, rsp_valid, (trigger_zone != TZONE_NONE) == (alarm_state == MODE_TRIGGERED), "trigger zone and state disagree")

   // any change must also ask for a report
   `ZIA_ASSERT_IMPLY(a_change_reports, clock, reset, rsp_valid && changed, report, "change without report")

endmodule

bind zoned_intrusion_alarm_fsm_unit zia_checker u_zia_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .alarm_state    (rsp_ch.alarm_state),
   .zone_enables   (rsp_ch.zone_enables),
   .sensors_active (rsp_ch.sensors_active),
   .trigger_zone   (rsp_ch.trigger_zone),
   .changed        (rsp_ch.changed),
   .report         (rsp_ch.report)
);

`default_nettype wire
